FILE: design/fts_pkg.sv
// Shared types, constants and helpers for the flat triangle span generator.
package fts_pkg;

   localparam int MaxScreen    = 4096;
   localparam int FracBits     = 16;
   localparam int SlopeDyLimit = 4096;

   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_STRIDE = 2'd2;

   localparam logic [1:0] ST_SETUP_OK  = 2'd0;
   localparam logic [1:0] ST_SETUP_REJ = 2'd1;
   localparam logic [1:0] ST_SPAN      = 2'd2;
   localparam logic [1:0] ST_IDLE_STEP = 2'd3;

   localparam logic ACT_SETUP = 1'b0;

   typedef struct packed {
      logic               action;
      logic signed [13:0] x0;
      logic signed [13:0] y0;
      logic signed [13:0] x1;
      logic signed [13:0] y1;
      logic signed [13:0] x2;
      logic signed [13:0] y2;
      logic               early_reject;
      logic [15:0]        shade;
   } cmd_type;

   localparam int QueueDepth = 2;

   function automatic logic [12:0] eff_dim(input logic [12:0] r);
      if (r == 13'd0) return 13'd1;
      if (r > 13'(MaxScreen)) return 13'(MaxScreen);
      return r;
   endfunction

endpackage

FILE: design/fts_front.sv
// Front end: takes items, sorts vertices by y and flags off-screen triangles for early reject.
module fts_front
   import fts_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_action,
   input  logic signed [13:0] req_vert_a_x,
   input  logic signed [13:0] req_vert_a_y,
   input  logic signed [13:0] req_vert_b_x,
   input  logic signed [13:0] req_vert_b_y,
   input  logic signed [13:0] req_vert_c_x,
   input  logic signed [13:0] req_vert_c_y,
   input  logic [15:0]        req_shade_index,
   input  logic [12:0]        height,
   output logic               cmd_valid,
   input  logic               cmd_ready,
   output cmd_type            cmd
);

   cmd_type    q_ff [QueueDepth];
   cmd_type    q_in;
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push, pop;
   logic signed [13:0] h;

   assign h = 14'(eff_dim(height));

   always_comb begin
      logic signed [13:0] ya, yb, yc;
      ya = req_vert_a_y; yb = req_vert_b_y; yc = req_vert_c_y;
      q_in.action = req_action;
      q_in.shade  = req_shade_index;
      if (ya <= yb && ya <= yc) begin
         if (yb <= yc) begin
            q_in.x0 = req_vert_a_x; q_in.y0 = ya; q_in.x1 = req_vert_b_x;
            q_in.y1 = yb; q_in.x2 = req_vert_c_x; q_in.y2 = yc;
         end else begin
            q_in.x0 = req_vert_a_x; q_in.y0 = ya; q_in.x1 = req_vert_c_x;
            q_in.y1 = yc; q_in.x2 = req_vert_b_x; q_in.y2 = yb;
         end
      end else if (yb <= yc) begin
         if (yc <= ya) begin
            q_in.x0 = req_vert_b_x; q_in.y0 = yb; q_in.x1 = req_vert_c_x;
            q_in.y1 = yc; q_in.x2 = req_vert_a_x; q_in.y2 = ya;
         end else begin
            q_in.x0 = req_vert_b_x; q_in.y0 = yb; q_in.x1 = req_vert_a_x;
            q_in.y1 = ya; q_in.x2 = req_vert_c_x; q_in.y2 = yc;
         end
      end else begin
         if (ya <= yb) begin
            q_in.x0 = req_vert_c_x; q_in.y0 = yc; q_in.x1 = req_vert_a_x;
            q_in.y1 = ya; q_in.x2 = req_vert_b_x; q_in.y2 = yb;
         end else begin
            q_in.x0 = req_vert_c_x; q_in.y0 = yc; q_in.x1 = req_vert_b_x;
            q_in.y1 = yb; q_in.x2 = req_vert_a_x; q_in.y2 = ya;
         end
      end
      q_in.early_reject = (q_in.y0 >= h) || (q_in.y2 < 0);
   end

   assign req_ready = (count_ff != 2'(QueueDepth));
   assign push      = req_valid && req_ready;
   assign cmd_valid = (count_ff != 2'd0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd       = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ptr_ff] <= q_in;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

FILE: design/fts_divider.sv
// Iterative signed divider: quotient truncated toward zero, one bit per cycle.
module fts_divider
   import fts_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] dividend,
   input  logic [12:0]        divisor,
   output logic               done,
   output logic signed [31:0] quotient
);

   logic [31:0] num_ff, quo_ff;
   logic [13:0] rem_ff;
   logic [12:0] den_ff;
   logic        neg_ff, busy_ff, done_ff;
   logic [4:0]  cnt_ff;
   logic [13:0] trial;

   assign trial    = {rem_ff[12:0], num_ff[31]};
   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= dividend[31] ? 32'(-dividend) : 32'(dividend);
         neg_ff <= dividend[31];
         den_ff <= divisor;
         rem_ff <= 14'd0;
         quo_ff <= 32'd0;
      end else if (busy_ff) begin
         num_ff <= {num_ff[30:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_ff <= trial - {1'b0, den_ff};
            quo_ff <= {quo_ff[30:0], 1'b1};
         end else begin
            rem_ff <= trial;
            quo_ff <= {quo_ff[30:0], 1'b0};
         end
      end
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 5'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

FILE: design/fts_back.sv
// Back end: triangle setup sequencer, edge walker and span result register.
module fts_back
   import fts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   output logic        cmd_ready,
   input  cmd_type     cmd,
   input  logic [12:0] width,
   input  logic [12:0] height,
   input  logic [12:0] stride,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [11:0] rsp_row_index,
   output logic [23:0] rsp_start_address,
   output logic [11:0] rsp_first_x,
   output logic [11:0] rsp_pixel_count,
   output logic [15:0] rsp_span_shade,
   output logic        rsp_last
);

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_DIV_AC, S_DIV_AB, S_DIV_BC,
      S_CLIP0, S_CLIP1, S_FINISH, S_SPAN, S_SPAN2, S_OUT
   } state_type;

   state_type state_ff;
   cmd_type   c_ff;

   logic signed [47:0] long_x_ff, short_x_ff, second_x_ff;
   logic signed [31:0] sac_ff, sab_ff, sbc_ff;
   logic [12:0] up_left_ff, lo_left_ff;
   logic [11:0] row_ff;
   logic        long_right_ff, active_ff;
   logic [15:0] shade_ff;
   logic signed [14:0] y0_ff, y1_ff, y2_ff;
   logic signed [47:0] ab_ff, area_ff;
   logic [11:0] first_ff, count_ff;
   logic [23:0] row_mul_ff;

   logic [1:0]  o_status_ff;
   logic [11:0] o_row_ff, o_first_ff, o_count_ff;
   logic [23:0] o_addr_ff;
   logic [15:0] o_shade_ff;
   logic        o_last_ff, o_valid_ff;

   logic               div_start, div_done;
   logic signed [31:0] div_num, div_q;
   logic [12:0]        div_den;

   logic signed [14:0] dx01, dx02, dx12, dy01, dy02, dy12;
   logic signed [14:0] hh;

   assign dx01 = 15'(c_ff.x1) - 15'(c_ff.x0);
   assign dx02 = 15'(c_ff.x2) - 15'(c_ff.x0);
   assign dx12 = 15'(c_ff.x2) - 15'(c_ff.x1);
   assign dy01 = 15'(c_ff.y1) - 15'(c_ff.y0);
   assign dy02 = 15'(c_ff.y2) - 15'(c_ff.y0);
   assign dy12 = 15'(c_ff.y2) - 15'(c_ff.y1);
   assign hh   = 15'(eff_dim(height));

   fts_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_num),
      .divisor(div_den), .done(div_done), .quotient(div_q)
   );

   function automatic logic dy_ok(input logic signed [14:0] dy);
      return dy > 0 && dy < 15'(SlopeDyLimit);
   endfunction

   always_comb begin
      div_start = 1'b0;
      div_num   = 32'sd0;
      div_den   = 13'd1;
      case (state_ff)
         S_CHECK: begin
            div_start = dy_ok(dy02) && !c_ff.early_reject;
            div_num   = 32'(dx02) <<< FracBits;
            div_den   = 13'(dy02);
         end
         S_DIV_AC: begin
            div_start = (div_done || !dy_ok(dy02)) && dy_ok(dy01);
            div_num   = 32'(dx01) <<< FracBits;
            div_den   = 13'(dy01);
         end
         S_DIV_AB: begin
            div_start = (div_done || !dy_ok(dy01)) && dy_ok(dy12);
            div_num   = 32'(dx12) <<< FracBits;
            div_den   = 13'(dy12);
         end
         default: ;
      endcase
   end

   assign cmd_ready = (state_ff == S_IDLE) && !o_valid_ff;

   assign rsp_valid         = o_valid_ff;
   assign rsp_status        = o_status_ff;
   assign rsp_row_index     = o_row_ff;
   assign rsp_start_address = o_addr_ff;
   assign rsp_first_x       = o_first_ff;
   assign rsp_pixel_count   = o_count_ff;
   assign rsp_span_shade    = o_shade_ff;
   assign rsp_last          = o_last_ff;

   always_ff @(posedge clock) begin
      logic signed [47:0] st, en, xs, xe, wv;
      logic signed [14:0] ny1, ny2, ur, lr;
      logic [12:0] ul;
      logic        lr_right;
      if (reset) begin
         state_ff      <= S_IDLE;
         o_valid_ff    <= 1'b0;
         active_ff     <= 1'b0;
         long_x_ff     <= 48'sd0;
         short_x_ff    <= 48'sd0;
         second_x_ff   <= 48'sd0;
         sac_ff        <= 32'sd0;
         sab_ff        <= 32'sd0;
         sbc_ff        <= 32'sd0;
         up_left_ff    <= 13'd0;
         lo_left_ff    <= 13'd0;
         row_ff        <= 12'd0;
         long_right_ff <= 1'b0;
         shade_ff      <= 16'd0;
      end else begin
         if (o_valid_ff && rsp_ready) o_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (cmd_valid && cmd_ready) begin
                  c_ff <= cmd;
                  if (cmd.action == ACT_SETUP) begin
                     state_ff <= S_CHECK;
                  end else if (!active_ff) begin
                     o_status_ff <= ST_IDLE_STEP;
                     o_row_ff    <= 12'd0;
                     o_addr_ff   <= 24'd0;
                     o_first_ff  <= 12'd0;
                     o_count_ff  <= 12'd0;
                     o_shade_ff  <= 16'd0;
                     o_last_ff   <= 1'b1;
                     o_valid_ff  <= 1'b1;
                  end else begin
                     state_ff <= S_SPAN;
                  end
               end
            end
            S_CHECK: begin
               shade_ff    <= c_ff.shade;
               o_row_ff    <= 12'd0;
               o_addr_ff   <= 24'd0;
               o_first_ff  <= 12'd0;
               o_count_ff  <= 12'd0;
               o_shade_ff  <= c_ff.shade;
               area_ff     <= 48'(dx01) * 48'(dy02) - 48'(dx02) * 48'(dy01);
               sac_ff      <= 32'sd0;
               sab_ff      <= 32'sd0;
               sbc_ff      <= 32'sd0;
               if (c_ff.early_reject || dy02 == 15'sd0) begin
                  o_status_ff <= ST_SETUP_REJ;
                  o_last_ff   <= 1'b1;
                  o_valid_ff  <= 1'b1;
                  active_ff   <= 1'b0;
                  state_ff    <= S_IDLE;
               end else begin
                  state_ff <= S_DIV_AC;
               end
            end
            S_DIV_AC: begin
               if (div_done || !dy_ok(dy02)) begin
                  if (div_done) sac_ff <= div_q;
                  state_ff <= S_DIV_AB;
               end
            end
            S_DIV_AB: begin
               if (div_done || !dy_ok(dy01)) begin
                  if (div_done) sab_ff <= div_q;
                  state_ff <= S_DIV_BC;
               end
            end
            S_DIV_BC: begin
               if (div_done || !dy_ok(dy12)) begin
                  if (div_done) sbc_ff <= div_q;
                  state_ff <= S_CLIP0;
               end
            end
            S_CLIP0: begin
               if (area_ff == 48'sd0) begin
                  o_status_ff <= ST_SETUP_REJ;
                  o_last_ff   <= 1'b1;
                  o_valid_ff  <= 1'b1;
                  active_ff   <= 1'b0;
                  state_ff    <= S_IDLE;
               end else begin
                  y1_ff <= 15'(c_ff.y1);
                  y2_ff <= 15'(c_ff.y2);
                  ab_ff <= 48'(c_ff.x0) <<< FracBits;
                  if (c_ff.y0 < 0) begin
                     long_x_ff <= (48'(c_ff.x0) <<< FracBits) - 48'(sac_ff) * 48'(c_ff.y0);
                     y0_ff     <= 15'sd0;
                  end else begin
                     long_x_ff <= 48'(c_ff.x0) <<< FracBits;
                     y0_ff     <= 15'(c_ff.y0);
                  end
                  state_ff <= S_CLIP1;
               end
            end
            S_CLIP1: begin
               if (c_ff.y0 < 0)
                  ab_ff <= ab_ff - 48'(sab_ff) * 48'(c_ff.y0);
               if (c_ff.y1 < 0) begin
                  second_x_ff <= (48'(c_ff.x1) <<< FracBits) - 48'(sbc_ff) * 48'(c_ff.y1);
                  y1_ff       <= 15'sd0;
               end else begin
                  second_x_ff <= 48'(c_ff.x1) <<< FracBits;
               end
               state_ff <= S_FINISH;
            end
            S_FINISH: begin
               ny1 = y1_ff;
               ny2 = y2_ff;
               if (y1_ff >= hh) begin
                  ny1 = hh - 15'sd1;
                  ny2 = hh - 15'sd1;
               end else if (y2_ff >= hh) begin
                  ny2 = hh - 15'sd1;
               end
               lr_right = (y0_ff == ny1) ? (sac_ff <= sbc_ff) : (sac_ff >= sab_ff);
               ur = ny1 - y0_ff;
               lr = ny2 - ny1;
               if (ur < 0) ur = 15'sd0;
               if (lr < 0) lr = 15'sd0;
               long_right_ff <= lr_right;
               up_left_ff    <= 13'(ur);
               lo_left_ff    <= 13'(lr);
               row_ff        <= 12'(y0_ff);
               short_x_ff    <= (ur > 0) ? ab_ff : second_x_ff;
               active_ff     <= (ur + lr) > 0;
               o_status_ff   <= ST_SETUP_OK;
               o_last_ff     <= !((ur + lr) > 0);
               o_valid_ff    <= 1'b1;
               state_ff      <= S_IDLE;
            end
            S_SPAN: begin
               if (long_right_ff) begin
                  st = short_x_ff; en = long_x_ff;
               end else begin
                  st = long_x_ff; en = short_x_ff;
               end
               wv = 48'(eff_dim(width));
               xe = en >>> FracBits;
               if (xe >= wv) xe = wv - 48'sd1;
               xs = st >>> FracBits;
               if (xs < 0) xs = 48'sd0;
               if (st != en && xs < xe) begin
                  first_ff <= 12'(xs);
                  count_ff <= 12'(xe - xs);
               end else begin
                  first_ff <= 12'd0;
                  count_ff <= 12'd0;
               end
               row_mul_ff <= 24'(row_ff) * 24'(stride);
               state_ff   <= S_SPAN2;
            end
            S_SPAN2: begin
               o_status_ff <= ST_SPAN;
               o_row_ff    <= row_ff;
               o_addr_ff   <= row_mul_ff + 24'(first_ff);
               o_first_ff  <= first_ff;
               o_count_ff  <= count_ff;
               o_shade_ff  <= shade_ff;
               long_x_ff   <= long_x_ff + 48'(sac_ff);
               ul = up_left_ff;
               if (up_left_ff != 13'd0) begin
                  ul = up_left_ff - 13'd1;
                  up_left_ff <= ul;
                  short_x_ff <= (ul == 13'd0) ? second_x_ff : short_x_ff + 48'(sab_ff);
                  o_last_ff  <= (ul == 13'd0) && (lo_left_ff == 13'd0);
                  active_ff  <= !((ul == 13'd0) && (lo_left_ff == 13'd0));
               end else begin
                  short_x_ff <= short_x_ff + 48'(sbc_ff);
                  if (lo_left_ff != 13'd0) lo_left_ff <= lo_left_ff - 13'd1;
                  o_last_ff  <= (lo_left_ff <= 13'd1);
                  active_ff  <= !(lo_left_ff <= 13'd1);
               end
               row_ff     <= row_ff + 12'd1;
               o_valid_ff <= 1'b1;
               state_ff   <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

FILE: design/flat_triangle_span_generator.sv
// Top level of the flat triangle span generator: registers, front end and back end.
//
//   channel | ports          | handshake
//   --------+----------------+---------------------------
//   request | req_*          | req_valid / req_ready
//   result  | rsp_*          | rsp_valid / rsp_ready
//   config  | csr_*          | csr_write_enable, no wait
//
// A step holds the back end through take, span compute, and address and result
// register, and then until its result is taken. A setup runs take, check, a
// bit-serial division for each slope with dy in 1..4095 (none for other slopes),
// two clip states and finish, and is then held likewise until its result is taken.
// Reset is synchronous; a two-entry queue lets the front accept while the back works.
// The back end waits while its result register holds an untaken item.
module flat_triangle_span_generator
   import fts_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_action,
   input  logic signed [13:0] req_vert_a_x,
   input  logic signed [13:0] req_vert_a_y,
   input  logic signed [13:0] req_vert_b_x,
   input  logic signed [13:0] req_vert_b_y,
   input  logic signed [13:0] req_vert_c_x,
   input  logic signed [13:0] req_vert_c_y,
   input  logic [15:0]        req_shade_index,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [11:0]        rsp_row_index,
   output logic [23:0]        rsp_start_address,
   output logic [11:0]        rsp_first_x,
   output logic [11:0]        rsp_pixel_count,
   output logic [15:0]        rsp_span_shade,
   output logic               rsp_last,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [12:0]        csr_data
);

   logic [12:0] width_ff, height_ff, stride_ff;
   logic        cmd_valid, cmd_ready;
   cmd_type     cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 13'd512;
         height_ff <= 13'd384;
         stride_ff <= 13'd512;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_data;
            CSR_HEIGHT: height_ff <= csr_data;
            CSR_STRIDE: stride_ff <= csr_data;
            default: ;
         endcase
      end
   end

   fts_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_action(req_action), .req_vert_a_x(req_vert_a_x), .req_vert_a_y(req_vert_a_y),
      .req_vert_b_x(req_vert_b_x), .req_vert_b_y(req_vert_b_y),
      .req_vert_c_x(req_vert_c_x), .req_vert_c_y(req_vert_c_y),
      .req_shade_index(req_shade_index), .height(height_ff),
      .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
   );

   fts_back u_back (
      .clock(clock), .reset(reset), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
      .cmd(cmd), .width(width_ff), .height(height_ff), .stride(stride_ff),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_row_index(rsp_row_index), .rsp_start_address(rsp_start_address),
      .rsp_first_x(rsp_first_x), .rsp_pixel_count(rsp_pixel_count),
      .rsp_span_shade(rsp_span_shade), .rsp_last(rsp_last)
   );

endmodule

FILE: tb/sv/flat_triangle_span_generator_tb.sv
// Testbench for the flat triangle span generator: random setups and steps against a predictor.
`timescale 1ns / 1ps

module flat_triangle_span_generator_tb;
   import fts_pkg::*;

   localparam int WatchdogLimit = 3000;
   localparam int DrainCycles   = 200;
   localparam int LongHold      = 400;

   typedef struct {
      logic               action;
      logic signed [13:0] ax, ay, bx, by, cx, cy;
      logic [15:0]        shade;
   } tri_item_type;

   typedef struct {
      logic [1:0]  status;
      logic [11:0] row;
      logic [23:0] addr;
      logic [11:0] first;
      logic [11:0] count;
      logic [15:0] shade;
      logic        last;
   } span_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_action = 1'b0;
   logic signed [13:0] req_vert_a_x = '0, req_vert_a_y = '0, req_vert_b_x = '0;
   logic signed [13:0] req_vert_b_y = '0, req_vert_c_x = '0, req_vert_c_y = '0;
   logic [15:0] req_shade_index = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_status;
   logic [11:0] rsp_row_index, rsp_first_x, rsp_pixel_count;
   logic [23:0] rsp_start_address;
   logic [15:0] rsp_span_shade;
   logic rsp_last;
   logic csr_write_enable = 1'b0;
   logic [1:0] csr_index = CSR_WIDTH;
   logic [12:0] csr_data = '0;

   tri_item_type pending_items[$];
   span_type     expected_spans[$];
   int  mismatches = 0;
   int  send_idle_pct = 0;
   int  stall_pct = 0;
   bit  hold_request = 0;
   int  hold_left = 0;
   bit  req_taken = 0;
   int  quiet_cycles = 0;

   // predictor state
   logic [12:0] cfg_width = 13'd512, cfg_height = 13'd384, cfg_stride = 13'd512;
   longint long_x, short_x, second_x, long_slope, upper_slope, lower_slope;
   longint upper_rows, lower_rows, cur_row;
   bit     long_right, tri_active;
   logic [15:0] held_shade;

   flat_triangle_span_generator DUT (.*);

   always #5 clock = ~clock;

   function automatic longint clamp_dim(logic [12:0] r);
      if (r == 0) return 1;
      if (r > 4096) return 4096;
      return r;
   endfunction

   function automatic longint edge_slope(longint dx, longint dy);
      if (dy > 0 && dy < SlopeDyLimit) return (dx * 65536) / dy;
      return 0;
   endfunction

   function automatic bit load_sorted(longint x0, longint x1, longint x2,
                                      longint y0, longint y1, longint y2);
      longint h, ac, ab, bc, sac, sab, sbc;
      h = clamp_dim(cfg_height);
      if (y2 == y0) return 0;
      if ((x1 - x0) * (y2 - y0) - (x2 - x0) * (y1 - y0) == 0) return 0;
      sac = edge_slope(x2 - x0, y2 - y0);
      sab = edge_slope(x1 - x0, y1 - y0);
      sbc = edge_slope(x2 - x1, y2 - y1);
      ac = x0 * 65536;
      ab = ac;
      bc = x1 * 65536;
      if (y0 < 0) begin
         ac -= sac * y0; ab -= sab * y0; y0 = 0;
      end
      if (y1 < 0) begin
         bc -= sbc * y1; y1 = 0;
      end
      if (y1 >= h) begin
         y1 = h - 1; y2 = h - 1;
      end else if (y2 >= h) y2 = h - 1;
      long_right = (y0 == y1 && sac <= sbc) || (y0 != y1 && sac >= sab);
      upper_rows = (y1 - y0 < 0) ? 0 : y1 - y0;
      lower_rows = (y2 - y1 < 0) ? 0 : y2 - y1;
      cur_row = y0;
      long_x = ac;
      long_slope = sac;
      upper_slope = sab;
      lower_slope = sbc;
      second_x = bc;
      short_x = (upper_rows > 0) ? ab : bc;
      return 1;
   endfunction

   function automatic bit load_triangle(tri_item_type t);
      longint x0, y0, x1, y1, x2, y2, h;
      x0 = t.ax; y0 = t.ay; x1 = t.bx; y1 = t.by; x2 = t.cx; y2 = t.cy;
      h = clamp_dim(cfg_height);
      if (y0 <= y1 && y0 <= y2) begin
         if (y0 >= h) return 0;
         if (y1 <= y2) begin
            if (y2 < 0) return 0;
            return load_sorted(x0, x1, x2, y0, y1, y2);
         end
         if (y1 < 0) return 0;
         return load_sorted(x0, x2, x1, y0, y2, y1);
      end
      if (y1 <= y2) begin
         if (y1 >= h) return 0;
         if (y2 <= y0) begin
            if (y0 < 0) return 0;
            return load_sorted(x1, x2, x0, y1, y2, y0);
         end
         if (y2 < 0) return 0;
         return load_sorted(x1, x0, x2, y1, y0, y2);
      end
      if (y2 >= h) return 0;
      if (y0 <= y1) begin
         if (y1 < 0) return 0;
         return load_sorted(x2, x0, x1, y2, y0, y1);
      end
      if (y0 < 0) return 0;
      return load_sorted(x2, x1, x0, y2, y1, y0);
   endfunction

   function automatic span_type predict_span(tri_item_type t);
      span_type r;
      bit       ok;
      longint   s, e, xs, xe, first, count;
      r = '{default: '0};
      if (t.action == ACT_SETUP) begin
         ok = load_triangle(t);
         held_shade = t.shade;
         tri_active = ok && (upper_rows + lower_rows > 0);
         r.status = ok ? ST_SETUP_OK : ST_SETUP_REJ;
         r.shade = held_shade;
         r.last = !tri_active;
         return r;
      end
      if (!tri_active) begin
         r.status = ST_IDLE_STEP;
         r.last = 1;
         return r;
      end
      s = long_right ? short_x : long_x;
      e = long_right ? long_x : short_x;
      first = 0;
      count = 0;
      if (s != e) begin
         xe = e >>> FracBits;
         if (xe >= clamp_dim(cfg_width)) xe = clamp_dim(cfg_width) - 1;
         xs = s >>> FracBits;
         if (xs < 0) xs = 0;
         if (xs < xe) begin
            first = xs; count = xe - xs;
         end
      end
      r.status = ST_SPAN;
      r.row = cur_row[11:0];
      r.addr = 24'(cur_row * longint'(cfg_stride) + first);
      r.first = first[11:0];
      r.count = count[11:0];
      r.shade = held_shade;
      long_x += long_slope;
      if (upper_rows > 0) begin
         short_x += upper_slope;
         upper_rows--;
         if (upper_rows == 0) short_x = second_x;
      end else begin
         short_x += lower_slope;
         if (lower_rows > 0) lower_rows--;
      end
      cur_row++;
      if (upper_rows + lower_rows == 0) begin
         tri_active = 0;
         r.last = 1;
      end
      return r;
   endfunction

   task automatic report(string field, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
      mismatches++;
   endtask

   // monitor and checker
   always @(posedge clock) begin
      span_type w;
      req_taken <= req_valid && req_ready && !reset;
      if (reset) quiet_cycles <= 0;
      else begin
         quiet_cycles <= ((req_valid && req_ready) || (rsp_valid && rsp_ready)) ? 0 :
                         quiet_cycles + 1;
         if (rsp_valid && rsp_ready) begin
            if (expected_spans.size() == 0) report("unexpected item", rsp_status, -1);
            else begin
               w = expected_spans.pop_front();
               if (rsp_status !== w.status) report("status", rsp_status, w.status);
               if (rsp_row_index !== w.row) report("row_index", rsp_row_index, w.row);
               if (rsp_start_address !== w.addr)
                  report("start_address", rsp_start_address, w.addr);
               if (rsp_first_x !== w.first) report("first_x", rsp_first_x, w.first);
               if (rsp_pixel_count !== w.count)
                  report("pixel_count", rsp_pixel_count, w.count);
               if (rsp_span_shade !== w.shade) report("span_shade", rsp_span_shade, w.shade);
               if (rsp_last !== w.last) report("last", rsp_last, w.last);
            end
         end
         if (req_valid && req_ready)
            expected_spans.push_back(predict_span('{req_action, req_vert_a_x, req_vert_a_y,
               req_vert_b_x, req_vert_b_y, req_vert_c_x, req_vert_c_y, req_shade_index}));
         if (quiet_cycles >= WatchdogLimit) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      tri_item_type nx;
      if (!reset && (!req_valid || req_taken)) begin
         if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            nx = pending_items.pop_front();
            req_valid <= 1'b1;
            req_action <= nx.action;
            req_vert_a_x <= nx.ax; req_vert_a_y <= nx.ay;
            req_vert_b_x <= nx.bx; req_vert_b_y <= nx.by;
            req_vert_c_x <= nx.cx; req_vert_c_y <= nx.cy;
            req_shade_index <= nx.shade;
         end else req_valid <= 1'b0;
      end
   end

   // result backpressure
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_request) begin
         hold_request <= 0;
         hold_left <= LongHold;
         rsp_ready <= 1'b0;
      end else rsp_ready <= $urandom_range(99) >= stall_pct;
   end

   task automatic add_setup(int ax, int ay, int bx, int by, int cx, int cy, int shade);
      tri_item_type t;
      t = '{ACT_SETUP, 14'(ax), 14'(ay), 14'(bx), 14'(by), 14'(cx), 14'(cy), 16'(shade)};
      pending_items.push_back(t);
   endtask

   task automatic add_steps(int n);
      tri_item_type t;
      repeat (n) begin
         t = '{1'b1, 14'($urandom), 14'($urandom), 14'($urandom), 14'($urandom),
               14'($urandom), 14'($urandom), 16'($urandom)};
         pending_items.push_back(t);
      end
   endtask

   task automatic write_csr(logic [1:0] idx, logic [12:0] val);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_WIDTH:  cfg_width = val;
         CSR_HEIGHT: cfg_height = val;
         default:    cfg_stride = val;
      endcase
   endtask

   task automatic wait_drained();
      wait (pending_items.size() == 0 && !req_valid && expected_spans.size() == 0);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // one random triangle, mostly near the visible area, followed by some row steps
   task automatic add_random_triangle();
      int w, h, yb, xb, span;
      w = clamp_dim(cfg_width);
      h = clamp_dim(cfg_height);
      if ($urandom_range(9) == 0) begin
         add_setup($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
         add_steps($urandom_range(3));
         return;
      end
      span = ($urandom_range(19) == 0) ? 300 : 8;
      yb = $urandom_range((h > 200 ? 200 : h) + 10) - 10;
      xb = $urandom_range((w > 300 ? 300 : w) + 20) - 20;
      add_setup(xb + $urandom_range(2 * span) - span, yb + $urandom_range(2 * span) - span,
                xb + $urandom_range(40) - 20, yb + $urandom_range(span),
                xb + $urandom_range(60) - 30, yb + $urandom_range(2 * span) - span,
                $urandom);
      add_steps($urandom_range(14));
   endtask

   initial begin
      logic [12:0] dims[6][3];
      int          idle_modes[4][2];
      dims = '{'{13'd512, 13'd384, 13'd512}, '{13'd40, 13'd30, 13'd37},
               '{13'd4096, 13'd4096, 13'd4096}, '{13'd1, 13'd1, 13'd1},
               '{13'd0, 13'd0, 13'd0}, '{13'd8191, 13'd8191, 13'd8191}};
      idle_modes = '{'{0, 0}, '{69, 0}, '{0, 69}, '{34, 34}};
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed
      add_steps(1);
      add_setup(-8192, -8192, -8192, -8192, -8192, -8192, 0);
      add_setup(8191, 8191, 8191, 8191, 8191, 8191, 16'hFFFF);
      add_setup(10, 5, 50, 5, 30, 5, 1);
      add_setup(0, 0, 10, 10, 20, 20, 2);
      add_setup(0, -50, 20, -40, 10, -1, 3);
      add_setup(0, 400, 20, 410, 10, 500, 4);
      add_setup(10, 2, 40, 2, 20, 6, 5);
      add_steps(5);
      add_setup(20, 6, 10, 2, 40, 2, 6);
      add_steps(5);
      add_setup(-30, -3, 600, 1, 100, 4, 7);
      add_steps(3);
      add_setup(5, -5000, 8191, 2, -8192, 3, 8);
      add_steps(3);
      add_setup(100, 380, 150, 390, 120, 400, 9);
      add_steps(5);

      for (int ph = 0; ph < 6; ph++) begin
         wait_drained();
         write_csr(CSR_WIDTH, dims[ph][0]);
         write_csr(CSR_HEIGHT, dims[ph][1]);
         write_csr(CSR_STRIDE, dims[ph][2]);
         for (int m = 0; m < 4; m++) begin
            send_idle_pct = idle_modes[m][0];
            stall_pct = idle_modes[m][1];
            repeat (6) add_random_triangle();
            if (ph == 1 && m == 0) hold_request = 1;
            wait (pending_items.size() == 0);
         end
      end

      wait (pending_items.size() == 0 && !req_valid && expected_spans.size() == 0);
      repeat (DrainCycles) @(posedge clock);
      if (mismatches == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
